[rtl/rctc_pkg.sv]
`default_nettype none
package rctc_pkg;

  // table size and field widths
  localparam int PEERS  = 16;
  localparam int ADDR_W = 48;
  localparam int ID_W   = 32;

  // slot index width and the power-of-two span of the minimum tree
  localparam int IDX_W  = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int TREE_N = 1 << IDX_W;

  // action codes
  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

endpackage
`default_nettype wire

[rtl/replay_counter_table_check_unit.sv]
`default_nettype none
// Per-source replay filter. A transaction is taken on any clock edge where
// start is high and busy is low; busy is high only while rst is asserted, so
// one transaction can be taken every cycle. Each transaction produces exactly
// one result, shown on accepted/new_peer with done high for a single cycle,
// once the transaction has passed the input register and then the result
// register; the receiver cannot stall it, so it must capture the result on
// that cycle. The cycle between the two registers holds the parallel address
// match over all table entries, the free-slot priority pick and the
// smallest-address compare tree used for eviction when the table is full.
// action = clear empties the table and reports accepted = 0, new_peer = 0.
module replay_counter_table_check_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [rctc_pkg::ADDR_W-1:0] origin_mac,
  input  logic [rctc_pkg::ID_W-1:0]   message_id,
  output logic                        done,
  output logic                        accepted,
  output logic                        new_peer
);

  // input register
  logic                        in_valid;
  logic                        in_action;
  logic [rctc_pkg::ADDR_W-1:0] in_mac;
  logic [rctc_pkg::ID_W-1:0]   in_id;

  // table
  logic [rctc_pkg::PEERS-1:0]  entry_valid;
  logic [rctc_pkg::PEERS-1:0]  entry_valid_next;
  logic [rctc_pkg::ADDR_W-1:0] peer_address [rctc_pkg::PEERS];
  logic [rctc_pkg::ID_W-1:0]   last_message [rctc_pkg::PEERS];

  // lookup
  logic [rctc_pkg::PEERS-1:0]  hit;
  logic                        hit_any;
  logic [rctc_pkg::ID_W-1:0]   hit_id;
  logic                        free_any;
  logic [rctc_pkg::IDX_W-1:0]  free_idx;
  logic [rctc_pkg::IDX_W-1:0]  min_idx;
  logic [rctc_pkg::ADDR_W-1:0] min_addr;

  // update
  logic [rctc_pkg::PEERS-1:0]  wr_en;
  logic                        accepted_next;
  logic                        new_peer_next;

  assign busy = rst;

  rctc_min_search u_min (
    .peer_address (peer_address),
    .min_idx      (min_idx),
    .min_addr     (min_addr)
  );

  // address match; stored addresses are unique, so at most one hit
  always_comb begin
    hit_id = '0;
    for (int i = 0; i < rctc_pkg::PEERS; i++) begin
      hit[i] = entry_valid[i] && (peer_address[i] == in_mac);
      if (hit[i]) begin
        hit_id = hit_id | last_message[i];
      end
    end
    hit_any = |hit;
  end

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int i = rctc_pkg::PEERS - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = rctc_pkg::IDX_W'(i);
      end
    end
    free_any = ~&entry_valid;
  end

  // decision and table write enables
  always_comb begin
    wr_en            = '0;
    accepted_next    = 1'b0;
    new_peer_next    = 1'b0;
    entry_valid_next = entry_valid;
    if (in_valid) begin
      if (in_action == rctc_pkg::ACT_CLEAR) begin
        entry_valid_next = '0;
      end else if (hit_any) begin
        // known source: only a strictly newer id passes
        if (in_id > hit_id) begin
          wr_en         = hit;
          accepted_next = 1'b1;
        end
      end else begin
        // unknown source: always fresh; insert, else evict smallest address unless the new one is smaller
        accepted_next = 1'b1;
        new_peer_next = 1'b1;
        if (free_any) begin
          for (int i = 0; i < rctc_pkg::PEERS; i++) begin
            wr_en[i] = (free_idx == rctc_pkg::IDX_W'(i));
          end
        end else if (!(in_mac < min_addr)) begin
          for (int i = 0; i < rctc_pkg::PEERS; i++) begin
            wr_en[i] = (min_idx == rctc_pkg::IDX_W'(i));
          end
        end
        entry_valid_next = entry_valid | wr_en;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      done        <= 1'b0;
      entry_valid <= '0;
    end else begin
      in_valid    <= start && !busy;
      done        <= in_valid;
      entry_valid <= entry_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_action <= action;
    in_mac    <= origin_mac;
    in_id     <= message_id;
    accepted  <= accepted_next;
    new_peer  <= new_peer_next;
    for (int i = 0; i < rctc_pkg::PEERS; i++) begin
      if (wr_en[i]) begin
        peer_address[i] <= in_mac;
        last_message[i] <= in_id;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rctc_min_search.sv]
`default_nettype none
// Finds the slot holding the numerically smallest address. Balanced compare
// tree; on a tie the lower slot wins. Pad leaves hold all ones and sit to the
// right of every real slot, so they never win.
module rctc_min_search (
  input  logic [rctc_pkg::ADDR_W-1:0] peer_address [rctc_pkg::PEERS],
  output logic [rctc_pkg::IDX_W-1:0]  min_idx,
  output logic [rctc_pkg::ADDR_W-1:0] min_addr
);

  logic [rctc_pkg::ADDR_W-1:0] lvl_addr [rctc_pkg::IDX_W+1][rctc_pkg::TREE_N];
  logic [rctc_pkg::IDX_W-1:0]  lvl_idx  [rctc_pkg::IDX_W+1][rctc_pkg::TREE_N];

  always_comb begin
    // defaults keep unused nodes defined
    for (int l = 0; l <= rctc_pkg::IDX_W; l++) begin
      for (int n = 0; n < rctc_pkg::TREE_N; n++) begin
        lvl_addr[l][n] = '0;
        lvl_idx[l][n]  = '0;
      end
    end
    // leaves
    for (int n = 0; n < rctc_pkg::TREE_N; n++) begin
      if (n < rctc_pkg::PEERS) begin
        lvl_addr[0][n] = peer_address[n];
      end else begin
        lvl_addr[0][n] = '1;
      end
      lvl_idx[0][n] = rctc_pkg::IDX_W'(n);
    end
    // pairwise reduction, one level per index bit
    for (int l = 0; l < rctc_pkg::IDX_W; l++) begin
      for (int n = 0; n < (rctc_pkg::TREE_N >> (l + 1)); n++) begin
        if (lvl_addr[l][2*n+1] < lvl_addr[l][2*n]) begin
          lvl_addr[l+1][n] = lvl_addr[l][2*n+1];
          lvl_idx[l+1][n]  = lvl_idx[l][2*n+1];
        end else begin
          lvl_addr[l+1][n] = lvl_addr[l][2*n];
          lvl_idx[l+1][n]  = lvl_idx[l][2*n];
        end
      end
    end
  end

  assign min_idx  = lvl_idx[rctc_pkg::IDX_W][0];
  assign min_addr = lvl_addr[rctc_pkg::IDX_W][0];

endmodule
`default_nettype wire
